### rtl/aphd_pkg.sv
// Shared constants, types and helpers of the all-pairs Hamming distance block.
package aphd_pkg;

   localparam int A_MAX   = 8;
   localparam int B_MAX   = 8;
   localparam int LEN_MAX = 64;

   localparam int IDX_W   = 3;
   localparam int POS_W   = 6;
   localparam int CHAR_W  = 8;
   localparam int ADDR_W  = IDX_W + POS_W;
   localparam int DEPTH   = A_MAX * LEN_MAX;
   localparam int CNT_W   = 4;
   localparam int LEN_W   = 7;
   localparam int DIST_W  = 7;
   localparam int TOTAL_W = 13;
   localparam int CSR_A_W = 2;

   localparam logic [CSR_A_W-1:0] CSR_A_COUNT       = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_B_COUNT       = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_STRING_LENGTH = 2'd2;

   localparam logic SET_A = 1'b0;
   localparam logic SET_B = 1'b1;

   // Saturated run settings handed to the sequencer.
   typedef struct packed {
      logic [CNT_W-1:0] na;
      logic [CNT_W-1:0] nb;
      logic [LEN_W-1:0] len;
   } run_cfg_type;

   // Read addresses of both string stores.
   typedef struct packed {
      logic [ADDR_W-1:0] a_addr;
      logic [ADDR_W-1:0] b_addr;
   } rd_req_type;

   // One pair result.
   typedef struct packed {
      logic                last_pair;
      logic [TOTAL_W-1:0]  total_sum;
      logic [DIST_W-1:0]   distance;
      logic [IDX_W-1:0]    b_index;
      logic [IDX_W-1:0]    a_index;
   } result_type;

   function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] v,
                                                input logic [CNT_W-1:0] lim);
      return (v > lim) ? lim : v;
   endfunction

   function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] v);
      return (v > LEN_W'(LEN_MAX)) ? LEN_W'(LEN_MAX) : v;
   endfunction

endpackage

### rtl/aphd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module aphd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/aphd_seq.sv
// Pair sequencer: walks all A/B pairs, reads both stores and counts differences.
module aphd_seq (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  aphd_pkg::run_cfg_type           cfg,
   output aphd_pkg::rd_req_type            rd_req,
   input  logic [aphd_pkg::CHAR_W-1:0]     a_data,
   input  logic [aphd_pkg::CHAR_W-1:0]     b_data,
   output logic                            idle,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output aphd_pkg::result_type            rsp
);

   typedef enum logic [1:0] {
      IDLE,
      READ,
      DRAIN,
      EMIT
   } state_type;

   state_type                          state_ff, state_in;
   logic [aphd_pkg::IDX_W-1:0]         i_ff, i_in;
   logic [aphd_pkg::IDX_W-1:0]         j_ff, j_in;
   logic [aphd_pkg::POS_W-1:0]         k_ff, k_in;
   logic                               cmp_vld_ff, cmp_vld_in;
   logic [aphd_pkg::DIST_W-1:0]        dist_ff, dist_in;
   logic [aphd_pkg::TOTAL_W-1:0]       total_ff, total_in;
   logic                               rsp_vld_ff, rsp_vld_in;
   aphd_pkg::result_type               rsp_ff, rsp_in;

   logic                               load;
   logic                               i_last, j_last, k_last;
   logic [aphd_pkg::TOTAL_W-1:0]       total_next;

   assign i_last = ({1'b0, i_ff} == (cfg.na - aphd_pkg::CNT_W'(1)));
   assign j_last = ({1'b0, j_ff} == (cfg.nb - aphd_pkg::CNT_W'(1)));
   assign k_last = ({1'b0, k_ff} == (cfg.len - aphd_pkg::LEN_W'(1)));
   assign load   = (state_ff == EMIT) && (!rsp_vld_ff || rsp_ready);
   assign total_next = total_ff + aphd_pkg::TOTAL_W'(dist_ff);

   assign rd_req.a_addr = {i_ff, k_ff};
   assign rd_req.b_addr = {j_ff, k_ff};

   always_comb begin
      state_in   = state_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      cmp_vld_in = 1'b0;
      dist_in    = dist_ff + aphd_pkg::DIST_W'(cmp_vld_ff && (a_data != b_data));
      total_in   = total_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_ready;
      rsp_in     = rsp_ff;

      unique case (state_ff)
         IDLE: begin
            if (start && (cfg.na != '0) && (cfg.nb != '0)) begin
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               dist_in  = '0;
               total_in = '0;
               state_in = (cfg.len == '0) ? EMIT : READ;
            end
         end
         READ: begin
            cmp_vld_in = 1'b1;
            k_in       = k_ff + aphd_pkg::POS_W'(1);
            if (k_last) begin
               state_in = DRAIN;
            end
         end
         DRAIN: begin
            state_in = EMIT;
         end
         EMIT: begin
            if (load) begin
               rsp_vld_in       = 1'b1;
               rsp_in.a_index   = i_ff;
               rsp_in.b_index   = j_ff;
               rsp_in.distance  = dist_ff;
               rsp_in.total_sum = total_next;
               rsp_in.last_pair = i_last && j_last;
               total_in         = total_next;
               dist_in          = '0;
               k_in             = '0;
               if (j_last) begin
                  j_in = '0;
                  i_in = i_ff + aphd_pkg::IDX_W'(1);
               end else begin
                  j_in = j_ff + aphd_pkg::IDX_W'(1);
               end
               if (i_last && j_last) begin
                  state_in = IDLE;
               end else begin
                  state_in = (cfg.len == '0) ? EMIT : READ;
               end
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= IDLE;
         cmp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         total_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         total_ff   <= total_in;
      end
      i_ff    <= i_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
      dist_ff <= dist_in;
      rsp_ff  <= rsp_in;
   end

   assign idle      = (state_ff == IDLE);
   assign rsp_valid = rsp_vld_ff;
   assign rsp       = rsp_ff;

endmodule

### rtl/all_pairs_hamming_distance.sv
// A load beat with tlast starts a run when both the A and the B count are nonzero. Each pair
// takes one store read per character, a drain step and an output step, which waits while
// the previous result is still stalled; with string_length zero it is the output step alone.
// Throughput: one load beat per cycle while idle; no load beat is taken during a run.
// Reset is synchronous and active high; it clears control state and sets the counts and the string length to 1.
// String stores are not cleared and hold garbage until loaded.
module all_pairs_hamming_distance (
   input  logic        clock,
   input  logic        reset,

   // Load channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // string_index[2:0], char_position[8:3], char_value[16:9]
   input  logic        req_tuser,   // which_set
   input  logic        req_tlast,   // load_done

   // Pair result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // a_index[2:0], b_index[5:3], distance[12:6],
                                    // total_sum[25:13]
   output logic        rsp_tlast,   // last_pair

   // Register write port.
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [6:0]  csr_wdata
);

   logic [aphd_pkg::CNT_W-1:0]   a_count_ff, a_count_in;
   logic [aphd_pkg::CNT_W-1:0]   b_count_ff, b_count_in;
   logic [aphd_pkg::LEN_W-1:0]   len_ff, len_in;

   aphd_pkg::run_cfg_type        run_cfg;
   aphd_pkg::rd_req_type         rd_req;
   aphd_pkg::result_type         result;

   logic                         req_beat;
   logic                         idle;
   logic [aphd_pkg::ADDR_W-1:0]  wr_addr;
   logic [aphd_pkg::CHAR_W-1:0]  wr_char;
   logic [aphd_pkg::CHAR_W-1:0]  a_data, b_data;

   // Register writes; an index past the last register is dropped.
   always_comb begin
      a_count_in = a_count_ff;
      b_count_in = b_count_ff;
      len_in     = len_ff;
      if (csr_we) begin
         unique case (csr_addr)
            aphd_pkg::CSR_A_COUNT:       a_count_in = csr_wdata[aphd_pkg::CNT_W-1:0];
            aphd_pkg::CSR_B_COUNT:       b_count_in = csr_wdata[aphd_pkg::CNT_W-1:0];
            aphd_pkg::CSR_STRING_LENGTH: len_in     = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_count_ff <= aphd_pkg::CNT_W'(1);
         b_count_ff <= aphd_pkg::CNT_W'(1);
         len_ff     <= aphd_pkg::LEN_W'(1);
      end else begin
         a_count_ff <= a_count_in;
         b_count_ff <= b_count_in;
         len_ff     <= len_in;
      end
   end

   // Counts above the store sizes saturate to the store sizes.
   assign run_cfg.na  = aphd_pkg::sat_cnt(a_count_ff, aphd_pkg::CNT_W'(aphd_pkg::A_MAX));
   assign run_cfg.nb  = aphd_pkg::sat_cnt(b_count_ff, aphd_pkg::CNT_W'(aphd_pkg::B_MAX));
   assign run_cfg.len = aphd_pkg::sat_len(len_ff);

   // Load beats are taken only between runs, so the stores never see a write
   // and a comparison read in the same cycle. Every index the fields can
   // carry lies inside the stores, so each beat writes its character.
   assign req_tready = idle;
   assign req_beat   = req_tvalid && req_tready;
   assign wr_addr    = {req_tdata[2:0], req_tdata[8:3]};
   assign wr_char    = req_tdata[16:9];

   aphd_ram #(
      .WIDTH (aphd_pkg::CHAR_W),
      .DEPTH (aphd_pkg::DEPTH)
   ) u_a_store (
      .clock   (clock),
      .wr_en   (req_beat && (req_tuser == aphd_pkg::SET_A)),
      .wr_addr (wr_addr),
      .wr_data (wr_char),
      .rd_addr (rd_req.a_addr),
      .rd_data (a_data)
   );

   aphd_ram #(
      .WIDTH (aphd_pkg::CHAR_W),
      .DEPTH (aphd_pkg::DEPTH)
   ) u_b_store (
      .clock   (clock),
      .wr_en   (req_beat && (req_tuser == aphd_pkg::SET_B)),
      .wr_addr (wr_addr),
      .wr_data (wr_char),
      .rd_addr (rd_req.b_addr),
      .rd_data (b_data)
   );

   // The sequencer starts, if both counts are nonzero, in the cycle after the tlast beat,
   // when the final character is already in its store.
   aphd_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (req_beat && req_tlast),
      .cfg       (run_cfg),
      .rd_req    (rd_req),
      .a_data    (a_data),
      .b_data    (b_data),
      .idle      (idle),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (result)
   );

   assign rsp_tdata = {6'b0, result.total_sum, result.distance, result.b_index, result.a_index};
   assign rsp_tlast = result.last_pair;

endmodule

### rtl/aphd_chk.sv
// Port-level checks of the all-pairs Hamming distance block, bound to the top level.
module aphd_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A stalled result beat keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // Reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A load beat without tlast never starts a run, so loading continues.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tlast |=> req_tready)
      else $error("load channel blocked after a plain load beat");

   // The padding bits above total_sum are always zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[31:26] == 6'b0))
      else $error("result padding bits set");

endmodule

bind all_pairs_hamming_distance aphd_chk u_aphd_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
